@@ sv/lksc_pkg.sv @@
package lksc_pkg;

  localparam int SLOTS_DEFAULT = 256;
  localparam int KEY_BITS_DEFAULT = 32;
  localparam logic [8:0] CAPACITY_RESET = 9'd256;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic        cmd;
    logic signed [31:0] key;
    logic        last_in_batch;
  } lksc_in_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  slot;
    logic        evicted;
    logic signed [31:0] reported_key;
    logic [15:0] batch_count;
    logic        batch_done;
  } lksc_out_t;

  typedef struct packed {
    logic key_we;
    logic older_we;
    logic newer_we;
  } lksc_mem_ctl_t;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

endpackage

@@ sv/lksc_store.sv @@
module lksc_store
  import lksc_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int KEY_BITS = KEY_BITS_DEFAULT,
  localparam int SLOT_BITS = $clog2(SLOTS)
) (
  input  logic                 clk,
  input  lksc_mem_ctl_t        ctl,
  input  logic [SLOT_BITS-1:0] key_addr,
  input  logic [KEY_BITS-1:0]  key_wdata,
  output logic [KEY_BITS-1:0]  key_rdata,
  input  logic [SLOT_BITS-1:0] older_addr,
  input  logic [SLOT_BITS-1:0] older_wdata,
  output logic [SLOT_BITS-1:0] older_rdata,
  input  logic [SLOT_BITS-1:0] newer_addr,
  input  logic [SLOT_BITS-1:0] newer_wdata,
  output logic [SLOT_BITS-1:0] newer_rdata
);

  logic [KEY_BITS-1:0]  key_mem   [SLOTS];
  logic [SLOT_BITS-1:0] older_mem [SLOTS];
  logic [SLOT_BITS-1:0] newer_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[key_addr] <= key_wdata;
    end
    key_rdata <= key_mem[key_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.older_we) begin
      older_mem[older_addr] <= older_wdata;
    end
    older_rdata <= older_mem[older_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.newer_we) begin
      newer_mem[newer_addr] <= newer_wdata;
    end
    newer_rdata <= newer_mem[newer_addr];
  end

endmodule

@@ sv/lru_key_slot_cache_unit.sv @@
// Key-to-slot map with least-recently-used replacement.
// Input beats (in_valid/in_ready, in_data) carry a command, a key and a batch
// end mark; each gives exactly one result beat on out_valid/out_ready/out_data.
// The capacity register is written through cfg_we/cfg_data; write it only while
// the block idles (the block itself does not enforce this). One item is worked
// on at a time. The key search reads the key memory one filled slot at a time,
// with a SCAN and a CMP state for each slot; the next beat is taken in the cycle
// after the result is loaded. The single port of the key memory and the list
// updates in the link memories set the pace of these steps.
// A new beat is taken while a finished result still waits in the output
// register; when the receiver stalls, the next result waits in its last state
// until the output register is free, and no further beat is taken meanwhile.
// Reset empties the cache at once, clears the batch count and sets the
// capacity to 256 slots. The memories need no clearing pass.
module lru_key_slot_cache_unit
  import lksc_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT,
  parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lksc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lksc_out_t out_data,
  input  logic      cfg_we,
  input  logic [8:0] cfg_data
);

  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int CW = (SLOT_BITS + 1 > 9) ? SLOT_BITS + 1 : 9;

  typedef enum logic [9:0] {
    IDLE  = 10'b0000000001,
    SCAN  = 10'b0000000010,
    CMP   = 10'b0000000100,
    EREAD = 10'b0000001000,
    EKEY  = 10'b0000010000,
    TREAD = 10'b0000100000,
    TLINK = 10'b0001000000,
    TPUSH = 10'b0010000000,
    INSRT = 10'b0100000000,
    FIN   = 10'b1000000000
  } state_t;

  state_t st;
  logic [8:0] capacity;
  logic [SLOT_BITS:0] nf;
  logic [SLOT_BITS-1:0] mr, lr, s;
  logic [SLOT_BITS:0] idx;
  logic [15:0] bcnt;
  logic [KEY_BITS-1:0] kbuf;
  logic [31:0] raw;
  logic cmd, last, hit, ev, counted;
  logic [31:0] rep;

  lksc_mem_ctl_t ctl;
  logic [SLOT_BITS-1:0] key_addr, older_addr, older_wdata, newer_addr, newer_wdata;
  logic [KEY_BITS-1:0] key_rdata;
  logic [SLOT_BITS-1:0] older_rdata, newer_rdata;

  logic [63:0] key_ext;
  logic [63:0] rd_ext;
  logic [CW-1:0] cap_x, cap_eff, nf_x;
  logic full;
  logic [15:0] cnt_val;
  logic [SLOT_BITS+7:0] slot_w;
  logic out_free;

  lksc_store #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .key_addr   (key_addr),
    .key_wdata  (kbuf),
    .key_rdata  (key_rdata),
    .older_addr (older_addr),
    .older_wdata(older_wdata),
    .older_rdata(older_rdata),
    .newer_addr (newer_addr),
    .newer_wdata(newer_wdata),
    .newer_rdata(newer_rdata)
  );

  assign in_ready = (st == IDLE);
  assign out_free = !out_valid || out_ready;
  assign key_ext = {{32{in_data.key[31]}}, in_data.key};
  assign rd_ext = 64'(key_rdata);
  assign cap_x = CW'(capacity);
  assign nf_x = CW'(nf);
  assign cap_eff = (capacity == 9'd0) ? CW'(1) :
                   ((cap_x > CW'(SLOTS)) ? CW'(SLOTS) : cap_x);
  assign full = (nf_x >= cap_eff);
  assign cnt_val = (counted && bcnt != COUNT_MAX) ? bcnt + 16'd1 : bcnt;
  assign slot_w = (SLOT_BITS + 8)'(s);

  always_comb begin
    ctl = '0;
    key_addr = s;
    older_addr = s;
    older_wdata = mr;
    newer_addr = s;
    newer_wdata = s;
    case (st)
      SCAN: begin
        key_addr = idx[SLOT_BITS-1:0];
      end
      EREAD: begin
        key_addr = lr;
      end
      EKEY: begin
        ctl.key_we = 1'b1;
      end
      INSRT: begin
        key_addr = nf[SLOT_BITS-1:0];
        ctl.key_we = 1'b1;
        if (nf != '0) begin
          ctl.older_we = 1'b1;
          older_addr = nf[SLOT_BITS-1:0];
          older_wdata = mr;
          ctl.newer_we = 1'b1;
          newer_addr = mr;
          newer_wdata = nf[SLOT_BITS-1:0];
        end
      end
      TLINK: begin
        if (s != mr && s != lr) begin
          ctl.older_we = 1'b1;
          older_addr = newer_rdata;
          older_wdata = older_rdata;
          ctl.newer_we = 1'b1;
          newer_addr = older_rdata;
          newer_wdata = newer_rdata;
        end
      end
      TPUSH: begin
        ctl.older_we = 1'b1;
        older_addr = s;
        older_wdata = mr;
        ctl.newer_we = 1'b1;
        newer_addr = mr;
        newer_wdata = s;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= IDLE;
      capacity <= CAPACITY_RESET;
      nf <= '0;
      mr <= '0;
      lr <= '0;
      bcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (st == FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        IDLE: begin
          if (in_valid) begin
            cmd <= in_data.cmd;
            raw <= in_data.key;
            last <= in_data.last_in_batch;
            kbuf <= key_ext[KEY_BITS-1:0];
            idx <= '0;
            s <= '0;
            hit <= 1'b0;
            ev <= 1'b0;
            counted <= 1'b0;
            rep <= '0;
            st <= SCAN;
          end
        end
        SCAN: begin
          if (idx == nf) begin
            if (cmd == CMD_LOOKUP) begin
              rep <= raw;
              counted <= 1'b1;
              st <= FIN;
            end else if (!full) begin
              st <= INSRT;
            end else begin
              st <= EREAD;
            end
          end else begin
            st <= CMP;
          end
        end
        CMP: begin
          if (key_rdata == kbuf) begin
            hit <= 1'b1;
            s <= idx[SLOT_BITS-1:0];
            st <= TREAD;
          end else begin
            idx <= idx + 1'b1;
            st <= SCAN;
          end
        end
        INSRT: begin
          s <= nf[SLOT_BITS-1:0];
          if (nf == '0) begin
            lr <= '0;
          end
          mr <= nf[SLOT_BITS-1:0];
          nf <= nf + 1'b1;
          st <= FIN;
        end
        EREAD: begin
          s <= lr;
          st <= EKEY;
        end
        EKEY: begin
          rep <= rd_ext[31:0];
          ev <= 1'b1;
          counted <= 1'b1;
          st <= TREAD;
        end
        TREAD: begin
          st <= TLINK;
        end
        TLINK: begin
          if (s == mr) begin
            st <= FIN;
          end else begin
            if (s == lr) begin
              lr <= newer_rdata;
            end
            st <= TPUSH;
          end
        end
        TPUSH: begin
          mr <= s;
          st <= FIN;
        end
        FIN: begin
          if (out_free) begin
            out_data.hit <= hit;
            out_data.slot <= slot_w[7:0];
            out_data.evicted <= ev;
            out_data.reported_key <= rep;
            out_data.batch_count <= cnt_val;
            out_data.batch_done <= last;
            bcnt <= last ? 16'd0 : cnt_val;
            st <= IDLE;
          end
        end
        default: begin
          st <= IDLE;
        end
      endcase
    end
  end

  a_nf_bound: assert property (@(posedge clk) disable iff (rst)
    nf <= (SLOT_BITS + 1)'(SLOTS))
    else $error("fill count beyond slot count");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (st == SCAN))
    else $error("accepted beat did not start a search");

  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    (st == FIN && out_free) |=> (out_valid && st == IDLE))
    else $error("result not loaded into output register");

  a_mr_filled: assert property (@(posedge clk) disable iff (rst)
    (st == IDLE && nf != '0) |-> ((SLOT_BITS + 1)'(mr) < nf && (SLOT_BITS + 1)'(lr) < nf))
    else $error("list end outside filled slots");

endmodule

@@ tb/sv/tb_lru_key_slot_cache_unit.sv @@
`timescale 1ns / 100ps

module tb_lru_key_slot_cache_unit;
  import lksc_pkg::*;

  localparam int N_SLOTS = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  class slot_map_scoreboard;
    logic [31:0] keys [N_SLOTS];
    bit          filled [N_SLOTS];
    logic [7:0]  newer [N_SLOTS];
    logic [7:0]  older [N_SLOTS];
    logic [7:0]  mru;
    logic [7:0]  lru;
    int          used;
    logic [15:0] misses_in_batch;
    logic [8:0]  capacity;
    lksc_out_t   pending [$];
    int          mismatches;
    int          results_seen;
    int          hits_seen;
    int          evictions_seen;

    function void clear();
      for (int i = 0; i < N_SLOTS; i++) filled[i] = 0;
      mru = 0;
      lru = 0;
      used = 0;
      misses_in_batch = 0;
      capacity = CAPACITY_RESET;
    endfunction

    function int limit_slots();
      if (capacity == 0) return 1;
      if (capacity > N_SLOTS) return N_SLOTS;
      return capacity;
    endfunction

    function void to_front(logic [7:0] s);
      if (s == mru) return;
      if (s == lru) begin
        lru = newer[s];
      end else begin
        older[newer[s]] = older[s];
        newer[older[s]] = newer[s];
      end
      older[s] = mru;
      newer[mru] = s;
      mru = s;
    endfunction

    function void note_item(lksc_in_t item);
      lksc_out_t r;
      bit found;
      bit counted;
      found = 0;
      counted = 0;
      r = '0;
      for (int i = 0; i < N_SLOTS; i++) begin
        if (!found && filled[i] && keys[i] == item.key) begin
          found = 1;
          r.slot = i[7:0];
        end
      end
      if (found) begin
        r.hit = 1;
        to_front(r.slot);
      end else if (item.cmd == CMD_LOOKUP) begin
        r.reported_key = item.key;
        counted = 1;
      end else if (used < limit_slots()) begin
        r.slot = used[7:0];
        keys[r.slot] = item.key;
        filled[r.slot] = 1;
        if (used == 0) begin
          mru = r.slot;
          lru = r.slot;
        end else begin
          older[r.slot] = mru;
          newer[mru] = r.slot;
          mru = r.slot;
        end
        used++;
      end else begin
        r.slot = lru;
        r.reported_key = keys[lru];
        r.evicted = 1;
        counted = 1;
        keys[lru] = item.key;
        to_front(r.slot);
      end
      if (counted && misses_in_batch != COUNT_MAX) misses_in_batch++;
      r.batch_count = misses_in_batch;
      r.batch_done = item.last_in_batch;
      if (item.last_in_batch) misses_in_batch = 0;
      pending.push_back(r);
    endfunction

    function void check_result(lksc_out_t got);
      lksc_out_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.hit) hits_seen++;
      if (got.evicted) evictions_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_ready;
  lksc_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 0;
  lksc_out_t  out_data;
  logic       cfg_we = 0;
  logic [8:0] cfg_data = '0;

  slot_map_scoreboard board = new();
  int  idle_cycles = 0;
  int  items_sent = 0;
  int  stall_mode = 0;
  bit  timed_out = 0;
  logic [31:0] key_pool [16];

  lru_key_slot_cache_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
    if (!rst && in_valid && in_ready) board.note_item(in_data);
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // The receiver alternates between free flow, light stalls and heavy stalls.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic c, logic [31:0] k, logic l);
    in_valid <= 1;
    in_data <= '{cmd: c, key: k, last_in_batch: l};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_capacity(logic [8:0] value);
    drain();
    cfg_we <= 1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    board.capacity = value;
  endtask

  task automatic pool_burst(int count, int pool_size, int insert_pct);
    int gap;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      send_item($urandom_range(0, 99) < insert_pct,
                $urandom_range(0, 19) == 0 ? $urandom : key_pool[$urandom_range(0, pool_size - 1)],
                $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    board.clear();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_capacity(9'd2);
    send_item(CMD_LOOKUP, 32'h8000_0000, 0);
    send_item(CMD_INSERT, 32'h8000_0000, 0);
    send_item(CMD_INSERT, 32'h7FFF_FFFF, 0);
    send_item(CMD_LOOKUP, 32'h8000_0000, 0);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 0);
    send_item(CMD_INSERT, 32'h0000_0000, 1);
    send_item(CMD_LOOKUP, 32'h0000_0000, 0);
    send_item(CMD_INSERT, 32'hFFFF_FFFF, 0);
    send_item(CMD_LOOKUP, 32'h7FFF_FFFF, 1);
    set_capacity(9'd0);
    send_item(CMD_INSERT, 32'h1234_5678, 0);
    send_item(CMD_INSERT, 32'h5555_AAAA, 1);
    set_capacity(9'h1FF);
    send_item(CMD_INSERT, 32'hAAAA_5555, 0);
    send_item(CMD_INSERT, 32'hAAAA_5554, 0);
    send_item(CMD_LOOKUP, 32'h1234_5678, 1);

    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
      case (phase)
        0: set_capacity(9'd1);
        1: set_capacity(9'd4);
        2: set_capacity(9'd256);
        3: set_capacity(9'd8);
        4: set_capacity(9'd3);
        default: set_capacity(9'd2);
      endcase
      pool_burst(250, phase == 2 ? 16 : 10, 55);
      if (phase == 2) drain();
    end
    // The capacity is raised again after running over full, so new keys take free slots.
    set_capacity(9'd256);
    pool_burst(30, 16, 90);

    drain();
    $display("Sent %0d items, checked %0d results (%0d hits, %0d evictions).",
             items_sent, board.results_seen, board.hits_seen, board.evictions_seen);
    $display("Capacities 0, 1, 2, 3, 4, 8, 256 and 511 were used; mismatches: %0d.",
             board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/lksc_pkg.sv
sv/lksc_store.sv
sv/lru_key_slot_cache_unit.sv
tb/sv/tb_lru_key_slot_cache_unit.sv
